// File: sv/fpa_pkg.sv
// shared types and constants of the q24.8 fixed-point alu
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fpa_pkg;

	// fraction bits and working width of the operands
	localparam int FRAC_BITS  = 8;
	localparam int DATA_WIDTH = 32;

	// width of an operand field on the ports
	localparam int FIELD_W = 32;

	// bits of the divide dividend, one divide cell per bit
	localparam int QBITS = DATA_WIDTH + FRAC_BITS;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_INC      = 4'd10,
		OP_DEC      = 4'd11,
		OP_MIN      = 4'd12,
		OP_MAX      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	// everything one item carries down the divide chain
	typedef struct packed {
		op_t                   op;
		logic [DATA_WIDTH-1:0] value;  // result of every op but divide and the compares
		logic                  flag;
		logic                  dz;
		logic                  neg;    // quotient sign
		logic [DATA_WIDTH-1:0] rem;    // partial remainder
		logic [QBITS-1:0]      dq;     // dividend bits out, quotient bits in
		logic [DATA_WIDTH-1:0] md;     // divisor magnitude
	} cell_t;

endpackage

// File: sv/fpa_front.sv
// first stage: decodes the op, computes every non-divide result and
// prepares the divide magnitudes; depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  in_op,
	input  logic [fpa_pkg::FIELD_W-1:0] in_a,
	input  logic [fpa_pkg::FIELD_W-1:0] in_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fpa_pkg::cell_t              out_cell
);
	import fpa_pkg::*;

	logic signed [DATA_WIDTH-1:0]   a_s, b_s;
	logic signed [2*DATA_WIDTH-1:0] prod, prod_sh;
	logic signed [QBITS-1:0]        num;
	logic signed [DATA_WIDTH-1:0]   to_int;
	logic                           a_lt_b, b_lt_a;
	op_t                            op;
	cell_t                          nxt;
	logic                           valid_s1;
	cell_t                          cell_s1;

	assign op  = op_t'(in_op);
	assign a_s = $signed(in_a[DATA_WIDTH-1:0]);
	assign b_s = $signed(in_b[DATA_WIDTH-1:0]);

	// full signed product, then arithmetic shift by the fraction bits
	assign prod    = a_s * b_s;
	assign prod_sh = prod >>> FRAC_BITS;
	assign to_int  = a_s >>> FRAC_BITS;

	// dividend a << frac on the wide word
	assign num = QBITS'(a_s) <<< FRAC_BITS;

	assign a_lt_b = a_s < b_s;
	assign b_lt_a = b_s < a_s;

	// next stage contents
	always_comb begin
		nxt       = '0;
		nxt.op    = op;
		nxt.rem   = '0;
		nxt.neg   = a_s[DATA_WIDTH-1] ^ b_s[DATA_WIDTH-1];
		nxt.dq    = num[QBITS-1] ? QBITS'(-num) : QBITS'(num);
		nxt.md    = b_s[DATA_WIDTH-1] ? DATA_WIDTH'(-b_s) : DATA_WIDTH'(b_s);
		nxt.dz    = (op == OP_DIV) && (b_s == '0);
		case (op)
			OP_ADD:      nxt.value = DATA_WIDTH'(a_s + b_s);
			OP_SUB:      nxt.value = DATA_WIDTH'(a_s - b_s);
			OP_MUL:      nxt.value = prod_sh[DATA_WIDTH-1:0];
			OP_DIV:      nxt.value = '0;
			OP_GT:       nxt.flag  = b_lt_a;
			OP_LT:       nxt.flag  = a_lt_b;
			OP_GE:       nxt.flag  = !a_lt_b;
			OP_LE:       nxt.flag  = !b_lt_a;
			OP_EQ:       nxt.flag  = (a_s == b_s);
			OP_NE:       nxt.flag  = (a_s != b_s);
			OP_INC:      nxt.value = DATA_WIDTH'(a_s + 1);
			OP_DEC:      nxt.value = DATA_WIDTH'(a_s - 1);
			OP_MIN:      nxt.value = a_lt_b ? a_s : b_s;
			OP_MAX:      nxt.value = b_lt_a ? a_s : b_s;
			OP_FROM_INT: nxt.value = DATA_WIDTH'(a_s <<< FRAC_BITS);
			OP_TO_INT:   nxt.value = to_int;
			default:     nxt.value = '0;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cell_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_cell  = cell_s1;

endmodule

// File: sv/fpa_cell.sv
// one restoring divide step: brings down one dividend bit and emits one
// quotient bit, passing the item to the next cell; depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fpa_pkg::cell_t in_cell,
	output logic           out_valid,
	input  logic           out_ready,
	output fpa_pkg::cell_t out_cell
);
	import fpa_pkg::*;

	logic [DATA_WIDTH:0] trial;
	logic [DATA_WIDTH:0] diff;
	logic                ge;
	cell_t               nxt;
	logic                valid_q;
	cell_t               cell_q;

	// shift in the next dividend bit and try the subtraction
	assign trial = {in_cell.rem, in_cell.dq[QBITS-1]};
	assign diff  = trial - {1'b0, in_cell.md};
	assign ge    = trial >= {1'b0, in_cell.md};

	always_comb begin
		nxt     = in_cell;
		nxt.rem = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		nxt.dq  = {in_cell.dq[QBITS-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cell_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_q;

endmodule

// File: sv/fpa_back.sv
// output stage: applies the quotient sign and the zero divisor case,
// picks the result and holds it for the consumer; depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  fpa_pkg::cell_t              in_cell,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fpa_pkg::FIELD_W-1:0] out_value,
	output logic                        out_flag,
	output logic                        out_dz
);
	import fpa_pkg::*;

	logic [DATA_WIDTH-1:0] quo;
	logic [DATA_WIDTH-1:0] res;
	logic                  valid_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic                  flag_q;
	logic                  dz_q;

	// signed quotient, low bits kept
	assign quo = in_cell.neg ? DATA_WIDTH'(-in_cell.dq[DATA_WIDTH-1:0])
	                         : in_cell.dq[DATA_WIDTH-1:0];

	always_comb begin
		if (in_cell.op == OP_DIV) begin
			res = in_cell.dz ? '0 : quo;
		end else begin
			res = in_cell.value;
		end
	end

	assign in_ready = !valid_q || out_ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= res;
			flag_q  <= in_cell.flag;
			dz_q    <= in_cell.dz;
		end
	end

	assign out_valid = valid_q;
	assign out_value = FIELD_W'($signed(value_q));
	assign out_flag  = flag_q;
	assign out_dz    = dz_q;

endmodule

// File: sv/fixed_point_alu_q24_8.sv
// Signed fixed-point alu, 32-bit raw operands with 8 fraction bits. It takes one
// item per cycle while the output is not stalled and returns one result per item,
// in order, through one decode stage holding the 32x32 multiplier, a chain of QBITS
// restoring divide cells that each produce one quotient bit, and the output
// register. Every op travels the whole chain, so results never reorder. Divide by
// zero gives value 0 with div_by_zero set; divide overflow wraps.
// depends on fpa_pkg, fpa_front, fpa_cell, fpa_back
`timescale 1ns / 1ps

module fixed_point_alu_q24_8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // a [31:0], b [63:32]
	input  logic [3:0]  s_tuser,   // op [3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value [31:0]
	output logic [1:0]  m_tuser    // flag [0], div_by_zero [1]
);
	import fpa_pkg::*;

	logic  chain_valid [QBITS+1];
	logic  chain_ready [QBITS+1];
	cell_t chain_cell  [QBITS+1];
	logic  flag, dz;

	// decode, multiply and divide setup
	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_a      (s_tdata[FIELD_W-1:0]),
		.in_b      (s_tdata[2*FIELD_W-1:FIELD_W]),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_cell  (chain_cell[0])
	);

	// divide chain, one quotient bit per cell
	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		fpa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_cell   (chain_cell[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_cell  (chain_cell[i+1])
		);
	end

	// result select and output register
	fpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[QBITS]),
		.in_ready  (chain_ready[QBITS]),
		.in_cell   (chain_cell[QBITS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata),
		.out_flag  (flag),
		.out_dz    (dz)
	);

	assign m_tuser = {dz, flag};

endmodule
